[rtl/core/prt_pkg.sv]
// ----------------------------------------------------------------------------
// Process region table package
// Shared constants, request codes and record types.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int PROCESS_SLOTS       = 16;
    localparam int REGIONS_PER_PROCESS = 8;

    localparam logic [31:0] AUTO_BASE_RST   = 32'h7000_0000;
    localparam logic [31:0] AUTO_STRIDE_RST = 32'h0001_0000;

    localparam int KIND_W       = 2;
    localparam int PID_W        = 32;
    localparam int ADDR_W       = 64;
    localparam int ATTR_W       = 8;
    localparam int FOUND_SLOT_W = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 176;
    localparam int OUT_TDATA_W  = 216;

    localparam logic [KIND_W-1:0] KIND_MAP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNMAP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_STRIDE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [ATTR_W-1:0] prot;
        logic [ATTR_W-1:0] flags;
    } t_region;

    typedef struct packed {
        logic                    status;
        logic [ADDR_W-1:0]       mapped;
        logic [FOUND_SLOT_W-1:0] slot;
        t_region                 region;
    } t_result;

endpackage

[rtl/core/prt_slot_mem.sv]
// ----------------------------------------------------------------------------
// Process slot memory
// Owner id and region count per process slot; one read, one write port.
// ----------------------------------------------------------------------------
module prt_slot_mem #(
    parameter int SLOTS   = prt_pkg::PROCESS_SLOTS,
    parameter int COUNT_W = $clog2(prt_pkg::REGIONS_PER_PROCESS + 1),
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [SW-1:0]              i_rd_idx,
    output logic [prt_pkg::PID_W-1:0]  o_rd_owner,
    output logic [COUNT_W-1:0]         o_rd_count,
    input  logic                       i_wr_en,
    input  logic [SW-1:0]              i_wr_idx,
    input  logic [prt_pkg::PID_W-1:0]  i_wr_owner,
    input  logic [COUNT_W-1:0]         i_wr_count
);
    logic [prt_pkg::PID_W-1:0] mem_owner [SLOTS];
    logic [COUNT_W-1:0]        mem_count [SLOTS];
    logic [SLOTS-1:0]          r_used;
    logic                      r_rd_used;
    logic [prt_pkg::PID_W-1:0] r_rd_owner;
    logic [COUNT_W-1:0]        r_rd_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_owner[i_wr_idx] <= i_wr_owner;
            mem_count[i_wr_idx] <= i_wr_count;
        end
        if (i_rd_en) begin
            r_rd_owner <= mem_owner[i_rd_idx];
            r_rd_count <= mem_count[i_rd_idx];
        end
    end

    // unwritten slots read as free with no regions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_used[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_used <= r_used[i_rd_idx];
            end
        end
    end

    assign o_rd_owner = r_rd_used ? r_rd_owner : '0;
    assign o_rd_count = r_rd_used ? r_rd_count : '0;

endmodule

[rtl/core/prt_region_mem.sv]
// ----------------------------------------------------------------------------
// Region memory
// Region records per entry with valid flags cleared at reset.
// ----------------------------------------------------------------------------
module prt_region_mem #(
    parameter int ENTRIES = prt_pkg::PROCESS_SLOTS * prt_pkg::REGIONS_PER_PROCESS,
    localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [EW-1:0]     i_rd_idx,
    output logic              o_rd_valid,
    output prt_pkg::t_region  o_rd_data,
    input  logic              i_wr_en,
    input  logic              i_clr_en,
    input  logic [EW-1:0]     i_wr_idx,
    input  prt_pkg::t_region  i_wr_data
);
    prt_pkg::t_region mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic               r_rd_valid;
    prt_pkg::t_region   r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end else if (i_clr_en) begin
                r_valid[i_wr_idx] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_data  = r_rd_data;

endmodule

[rtl/core/process_region_table_core.sv]
// ----------------------------------------------------------------------------
// Process region table core
// Create, map, unmap and find over per-process region slots kept in memory.
// ----------------------------------------------------------------------------
// Id zero or a zero-length map skips to the result; create, and unmap or find of an
//   unknown process, end after the slot scan; else unmap and find scan the regions,
//   map after the address calculation. One transaction at a time, the next accepted
//   once the result loads; scans take one entry per cycle through one read port.
// Reset: synchronous active low; all slots free, all regions invalid, control and
//   configuration registers at their defaults. No clearing pass is needed.
module process_region_table_core #(
    parameter int PROCESS_SLOTS       = prt_pkg::PROCESS_SLOTS,
    parameter int REGIONS_PER_PROCESS = prt_pkg::REGIONS_PER_PROCESS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // process_id[31:0], address[95:32], length[159:96], protection[167:160],
    // map_flags[175:168]
    input  logic [prt_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // kind[1:0]
    input  logic [prt_pkg::KIND_W-1:0]           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // mapped_address[63:0], found_slot[66:64], found_start[130:67],
    // found_end[194:131], found_protection[202:195], found_flags[210:203]
    output logic [prt_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // status[0]
    output logic                                 o_m_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [prt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int SW  = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int SCW = $clog2(PROCESS_SLOTS + 1);
    localparam int RW  = (REGIONS_PER_PROCESS > 1) ? $clog2(REGIONS_PER_PROCESS) : 1;
    localparam int RCW = $clog2(REGIONS_PER_PROCESS + 1);
    localparam int CW  = $clog2(REGIONS_PER_PROCESS + 1);
    localparam int ENTRIES = PROCESS_SLOTS * REGIONS_PER_PROCESS;
    localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW  = CW + 32;
    localparam int AW  = prt_pkg::ADDR_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SSCAN = 4'd1;
    localparam logic [3:0] ST_SDEC  = 4'd2;
    localparam logic [3:0] ST_CALC0 = 4'd3;
    localparam logic [3:0] ST_CALC1 = 4'd4;
    localparam logic [3:0] ST_CALC2 = 4'd5;
    localparam logic [3:0] ST_RSCAN = 4'd6;
    localparam logic [3:0] ST_RDEC  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0]                    r_state;
    logic [prt_pkg::KIND_W-1:0]    r_kind;
    logic [prt_pkg::PID_W-1:0]     r_pid;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_len;
    logic [prt_pkg::ATTR_W-1:0]    r_prot;
    logic [prt_pkg::ATTR_W-1:0]    r_flg;
    logic [31:0]                   r_base;
    logic [31:0]                   r_stride;

    logic [SCW-1:0]                r_scnt;
    logic                          r_spend;
    logic [SW-1:0]                 r_spidx;
    logic                          r_m_found;
    logic [SW-1:0]                 r_m_idx;
    logic [CW-1:0]                 r_m_cnt;
    logic                          r_fc_found;
    logic [SW-1:0]                 r_fc_idx;
    logic [SW-1:0]                 r_sel;
    logic [CW-1:0]                 r_cnt_sel;

    logic [PW-1:0]                 r_prod;
    logic [AW-1:0]                 r_target;
    logic [AW-1:0]                 r_end;

    logic [RCW-1:0]                r_rcnt;
    logic                          r_rpend;
    logic [RW-1:0]                 r_rpidx;
    logic                          r_hit;
    logic [RW-1:0]                 r_hit_idx;
    prt_pkg::t_region              r_hit_data;

    prt_pkg::t_result              r_res;
    prt_pkg::t_result              r_out;
    logic                          r_ovalid;

    logic                          s_acc;
    logic [prt_pkg::PID_W-1:0]     in_pid;
    logic [AW-1:0]                 in_len;

    logic                          slot_rd_en;
    logic [prt_pkg::PID_W-1:0]     slot_owner;
    logic [CW-1:0]                 slot_count;
    logic                          slot_wr_en;
    logic [SW-1:0]                 slot_wr_idx;
    logic [CW-1:0]                 slot_wr_count;

    logic                          reg_rd_en;
    logic [EW-1:0]                 reg_rd_idx;
    logic                          reg_rd_valid;
    prt_pkg::t_region              reg_rd_data;
    logic                          reg_wr_en;
    logic                          reg_clr_en;
    logic [EW-1:0]                 reg_wr_idx;
    prt_pkg::t_region              reg_wr_data;
    logic                          reg_match;
    logic                          out_load;

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_pid      = i_s_tdata[31:0];
    assign in_len      = i_s_tdata[159:96];
    assign out_load    = (r_state == ST_FIN) && (!r_ovalid || i_m_tready);

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {5'd0, r_out.region.flags, r_out.region.prot,
                         r_out.region.end_addr, r_out.region.start_addr,
                         r_out.slot, r_out.mapped};

    // ---- memory access control ----
    assign slot_rd_en = (r_state == ST_SSCAN) && (r_scnt < SCW'(PROCESS_SLOTS));
    assign reg_rd_en  = (r_state == ST_RSCAN) && (r_rcnt < RCW'(REGIONS_PER_PROCESS));
    assign reg_rd_idx = EW'(r_sel) * EW'(REGIONS_PER_PROCESS) + EW'(r_rcnt[RW-1:0]);

    assign slot_wr_en = ((r_state == ST_SDEC) && (r_kind == prt_pkg::KIND_CREATE)
                         && r_fc_found)
                     || ((r_state == ST_RDEC) && ((r_kind == prt_pkg::KIND_MAP)
                         || ((r_kind == prt_pkg::KIND_UNMAP) && r_hit)));
    assign slot_wr_idx = (r_state == ST_SDEC) ? r_fc_idx : r_sel;

    always_comb begin
        if (r_state == ST_SDEC) begin
            slot_wr_count = '0;
        end else if (r_kind == prt_pkg::KIND_MAP) begin
            slot_wr_count = r_hit ? r_cnt_sel + CW'(1) : r_cnt_sel;
        end else begin
            slot_wr_count = (r_cnt_sel == '0) ? '0 : r_cnt_sel - CW'(1);
        end
    end

    assign reg_wr_en  = (r_state == ST_RDEC) && (r_kind == prt_pkg::KIND_MAP) && r_hit;
    assign reg_clr_en = (r_state == ST_RDEC) && (r_kind == prt_pkg::KIND_UNMAP) && r_hit;
    assign reg_wr_idx = EW'(r_sel) * EW'(REGIONS_PER_PROCESS) + EW'(r_hit_idx);
    assign reg_wr_data = '{start_addr: r_target, end_addr: r_end,
                           prot: r_prot, flags: r_flg};

    always_comb begin
        unique case (r_kind)
            prt_pkg::KIND_MAP:   reg_match = !reg_rd_valid;
            prt_pkg::KIND_UNMAP: reg_match = reg_rd_valid
                                             && (reg_rd_data.start_addr == r_addr);
            default:             reg_match = reg_rd_valid
                                             && (r_addr >= reg_rd_data.start_addr)
                                             && (r_addr < reg_rd_data.end_addr);
        endcase
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= prt_pkg::AUTO_BASE_RST;
            r_stride <= prt_pkg::AUTO_STRIDE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prt_pkg::CFG_AUTO_BASE:   r_base   <= i_cfg_data;
                prt_pkg::CFG_AUTO_STRIDE: r_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        if ((in_pid == '0) ||
                            ((i_s_tuser == prt_pkg::KIND_MAP) && (in_len == '0))) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_SSCAN;
                        end
                    end
                end
                ST_SSCAN: begin
                    if (!slot_rd_en && !r_spend) begin
                        r_state <= ST_SDEC;
                    end
                end
                ST_SDEC: begin
                    unique case (r_kind)
                        prt_pkg::KIND_CREATE: r_state <= ST_FIN;
                        prt_pkg::KIND_MAP:
                            r_state <= (r_m_found || r_fc_found) ? ST_CALC0 : ST_FIN;
                        default: r_state <= r_m_found ? ST_RSCAN : ST_FIN;
                    endcase
                end
                ST_CALC0: r_state <= ST_CALC1;
                ST_CALC1: r_state <= ST_CALC2;
                ST_CALC2: r_state <= ST_RSCAN;
                ST_RSCAN: begin
                    if (!reg_rd_en && !r_rpend) begin
                        r_state <= ST_RDEC;
                    end
                end
                ST_RDEC: r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    r_kind     <= i_s_tuser;
                    r_pid      <= in_pid;
                    r_addr     <= i_s_tdata[95:32];
                    r_len      <= in_len;
                    r_prot     <= i_s_tdata[167:160];
                    r_flg      <= i_s_tdata[175:168];
                    // status is the top field; everything else starts at zero
                    r_res      <= {prt_pkg::STATUS_FAIL,
                                   {($bits(prt_pkg::t_result) - 1){1'b0}}};
                    r_scnt     <= '0;
                    r_spend    <= 1'b0;
                    r_m_found  <= 1'b0;
                    r_fc_found <= 1'b0;
                end
            end
            ST_SSCAN: begin
                if (slot_rd_en) begin
                    r_scnt <= r_scnt + SCW'(1);
                end
                r_spend <= slot_rd_en;
                r_spidx <= r_scnt[SW-1:0];
                if (r_spend) begin
                    if (!r_m_found && (slot_owner == r_pid)) begin
                        r_m_found <= 1'b1;
                        r_m_idx   <= r_spidx;
                        r_m_cnt   <= slot_count;
                    end
                    if (!r_fc_found && ((slot_owner == '0) || (slot_owner == r_pid))) begin
                        r_fc_found <= 1'b1;
                        r_fc_idx   <= r_spidx;
                    end
                end
            end
            ST_SDEC: begin
                r_rcnt  <= '0;
                r_rpend <= 1'b0;
                r_hit   <= 1'b0;
                if (r_m_found) begin
                    r_sel     <= r_m_idx;
                    r_cnt_sel <= r_m_cnt;
                end else begin
                    // implicit create for map: fresh slot, count zero
                    r_sel     <= r_fc_idx;
                    r_cnt_sel <= '0;
                end
                if ((r_kind == prt_pkg::KIND_CREATE) && r_fc_found) begin
                    r_res.status <= prt_pkg::STATUS_OK;
                end
            end
            ST_CALC0: r_prod <= PW'(r_cnt_sel) * PW'(r_stride);
            ST_CALC1: r_target <= (r_addr == '0) ? AW'(r_base) + AW'(r_prod) : r_addr;
            ST_CALC2: r_end <= r_target + r_len;
            ST_RSCAN: begin
                if (reg_rd_en) begin
                    r_rcnt <= r_rcnt + RCW'(1);
                end
                r_rpend <= reg_rd_en;
                r_rpidx <= r_rcnt[RW-1:0];
                if (r_rpend && !r_hit && reg_match) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_rpidx;
                    r_hit_data <= reg_rd_data;
                end
            end
            ST_RDEC: begin
                if (r_hit) begin
                    r_res.status <= prt_pkg::STATUS_OK;
                    if (r_kind == prt_pkg::KIND_MAP) begin
                        r_res.mapped <= r_target;
                    end else if (r_kind == prt_pkg::KIND_FIND) begin
                        r_res.slot   <= prt_pkg::FOUND_SLOT_W'(r_hit_idx);
                        r_res.region <= r_hit_data;
                    end
                end
            end
            default: ;
        endcase
    end

    prt_slot_mem #(
        .SLOTS   (PROCESS_SLOTS),
        .COUNT_W (CW)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (slot_rd_en),
        .i_rd_idx   (r_scnt[SW-1:0]),
        .o_rd_owner (slot_owner),
        .o_rd_count (slot_count),
        .i_wr_en    (slot_wr_en),
        .i_wr_idx   (slot_wr_idx),
        .i_wr_owner (r_pid),
        .i_wr_count (slot_wr_count)
    );

    prt_region_mem #(
        .ENTRIES (ENTRIES)
    ) u_region_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (reg_rd_en),
        .i_rd_idx   (reg_rd_idx),
        .o_rd_valid (reg_rd_valid),
        .o_rd_data  (reg_rd_data),
        .i_wr_en    (reg_wr_en),
        .i_clr_en   (reg_clr_en),
        .i_wr_idx   (reg_wr_idx),
        .i_wr_data  (reg_wr_data)
    );

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != ST_IDLE))
        else $error("accepted transaction did not start");
    a_fin_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_tvalid)
        else $error("finished result not presented");
    a_region_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RSCAN) |-> (r_rcnt <= RCW'(REGIONS_PER_PROCESS)))
        else $error("region scan ran past slot");
    a_single_region_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(reg_wr_en && reg_clr_en))
        else $error("region set and clear together");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Process region table testbench
// Drives create, map, unmap and find requests over the stream ports. The
// scoreboard keeps its own copy of the slot table and checks every response
// field by field. The run changes the auto placement registers between
// phases and throttles both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SETTLE_CYCLES = prt_pkg::PROCESS_SLOTS + prt_pkg::REGIONS_PER_PROCESS + 16;
    localparam int HOLD_CYCLES   = 400;

    class region_table_scoreboard;
        logic [31:0]                base, stride;
        logic [prt_pkg::PID_W-1:0]  owner [prt_pkg::PROCESS_SLOTS];
        int                         count [prt_pkg::PROCESS_SLOTS];
        bit                         vld   [prt_pkg::PROCESS_SLOTS]
                                          [prt_pkg::REGIONS_PER_PROCESS];
        prt_pkg::t_region           rgn   [prt_pkg::PROCESS_SLOTS]
                                          [prt_pkg::REGIONS_PER_PROCESS];
        prt_pkg::t_result           pending [$];
        int                         errors;
        int                         checked;

        function new();
            base   = prt_pkg::AUTO_BASE_RST;
            stride = prt_pkg::AUTO_STRIDE_RST;
            foreach (owner[s]) begin
                owner[s] = '0;
                count[s] = 0;
            end
            foreach (vld[i, j]) vld[i][j] = 1'b0;
            errors  = 0;
            checked = 0;
        endfunction

        function int owned_slot(logic [prt_pkg::PID_W-1:0] pid);
            for (int s = 0; s < prt_pkg::PROCESS_SLOTS; s++)
                if (owner[s] == pid) return s;
            return -1;
        endfunction

        function int claim_slot(logic [prt_pkg::PID_W-1:0] pid);
            for (int s = 0; s < prt_pkg::PROCESS_SLOTS; s++) begin
                if (owner[s] == '0 || owner[s] == pid) begin
                    owner[s] = pid;
                    count[s] = 0;
                    return s;
                end
            end
            return -1;
        endfunction

        function void note_request(logic [prt_pkg::KIND_W-1:0] kind,
                                   logic [prt_pkg::PID_W-1:0] pid,
                                   logic [prt_pkg::ADDR_W-1:0] addr,
                                   logic [prt_pkg::ADDR_W-1:0] len,
                                   logic [prt_pkg::ATTR_W-1:0] prot,
                                   logic [prt_pkg::ATTR_W-1:0] flg);
            prt_pkg::t_result res;
            int s;
            logic [prt_pkg::ADDR_W-1:0] target;
            res = '0;
            res.status = prt_pkg::STATUS_FAIL;
            if (pid != '0) begin
                case (kind)
                    prt_pkg::KIND_CREATE: begin
                        if (claim_slot(pid) >= 0) res.status = prt_pkg::STATUS_OK;
                    end
                    prt_pkg::KIND_MAP: begin
                        s = (len == '0) ? -1 : owned_slot(pid);
                        if (len != '0 && s < 0) s = claim_slot(pid);
                        if (s >= 0) begin
                            target = addr;
                            if (target == '0)
                                target = {32'b0, base} + 64'(count[s]) * {32'b0, stride};
                            for (int r = 0; r < prt_pkg::REGIONS_PER_PROCESS; r++) begin
                                if (!vld[s][r]) begin
                                    rgn[s][r] = '{start_addr: target, end_addr: target + len,
                                                  prot: prot, flags: flg};
                                    vld[s][r] = 1'b1;
                                    count[s]++;
                                    res.status = prt_pkg::STATUS_OK;
                                    res.mapped = target;
                                    break;
                                end
                            end
                        end
                    end
                    prt_pkg::KIND_UNMAP: begin
                        s = owned_slot(pid);
                        if (s >= 0) begin
                            for (int r = 0; r < prt_pkg::REGIONS_PER_PROCESS; r++) begin
                                if (vld[s][r] && rgn[s][r].start_addr == addr) begin
                                    vld[s][r] = 1'b0;
                                    if (count[s] > 0) count[s]--;
                                    res.status = prt_pkg::STATUS_OK;
                                    break;
                                end
                            end
                        end
                    end
                    default: begin
                        s = owned_slot(pid);
                        if (s >= 0) begin
                            for (int r = 0; r < prt_pkg::REGIONS_PER_PROCESS; r++) begin
                                if (vld[s][r] && addr >= rgn[s][r].start_addr
                                        && addr < rgn[s][r].end_addr) begin
                                    res.status = prt_pkg::STATUS_OK;
                                    res.slot   = prt_pkg::FOUND_SLOT_W'(r);
                                    res.region = rgn[s][r];
                                    break;
                                end
                            end
                        end
                    end
                endcase
            end
            pending.push_back(res);
        endfunction

        function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
                         exp_v, act_v);
            end
        endfunction

        function void check_result(logic status, logic [prt_pkg::OUT_TDATA_W-1:0] data);
            prt_pkg::t_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %h/%h",
                         $realtime, status, data);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            compare("status", 64'(exp_r.status), 64'(status));
            compare("mapped_address", exp_r.mapped, data[63:0]);
            compare("found_slot", 64'(exp_r.slot), 64'(data[66:64]));
            compare("found_start", exp_r.region.start_addr, data[130:67]);
            compare("found_end", exp_r.region.end_addr, data[194:131]);
            compare("found_protection", 64'(exp_r.region.prot), 64'(data[202:195]));
            compare("found_flags", 64'(exp_r.region.flags), 64'(data[210:203]));
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [prt_pkg::IN_TDATA_W-1:0]    i_s_tdata;
    logic [prt_pkg::KIND_W-1:0]        i_s_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [prt_pkg::OUT_TDATA_W-1:0]   o_m_tdata;
    logic                              o_m_tuser;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [prt_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [prt_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    region_table_scoreboard table_sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  sent_items;
    int  mapped_pid [$];
    logic [prt_pkg::ADDR_W-1:0] mapped_start [$];
    event hold_start;
    bit   hold_off;

    process_region_table_core i_dut (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    always begin
        @(hold_start);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // receiver side: random stalls, plus the long hold-off
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready)
            table_sb.check_result(o_m_tuser, o_m_tdata);
    end

    task automatic write_reg(logic [prt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == prt_pkg::CFG_AUTO_BASE) table_sb.base = value;
        else table_sb.stride = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(logic [prt_pkg::KIND_W-1:0] kind,
                                logic [prt_pkg::PID_W-1:0] pid,
                                logic [prt_pkg::ADDR_W-1:0] addr,
                                logic [prt_pkg::ADDR_W-1:0] len,
                                logic [prt_pkg::ATTR_W-1:0] prot,
                                logic [prt_pkg::ATTR_W-1:0] flg);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {flg, prot, len, addr, pid};
        do @(posedge i_clk); while (!o_s_tready);
        table_sb.note_request(kind, pid, addr, len, prot, flg);
        sent_items++;
        if (kind == prt_pkg::KIND_MAP && pid != '0) begin
            mapped_pid.push_back(pid);
            mapped_start.push_back(addr);
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_request();
        int pick;
        int idx;
        logic [prt_pkg::PID_W-1:0]  pid;
        logic [prt_pkg::ADDR_W-1:0] addr;
        logic [prt_pkg::ADDR_W-1:0] len;
        logic [prt_pkg::ATTR_W-1:0] prot;
        logic [prt_pkg::ATTR_W-1:0] flg;
        pick = $urandom_range(0, 99);
        pid  = $urandom_range(1, 22);
        addr = ($urandom_range(0, 1) != 0) ? 64'h0 : {$urandom, $urandom};
        len  = 64'($urandom_range(1, 32'h2_0000));
        prot = 8'($urandom);
        flg  = 8'($urandom);
        if ($urandom_range(0, 9) == 0) len = {$urandom, $urandom};
        if ($urandom_range(0, 29) == 0) len = '0;
        if (mapped_pid.size() > 0 && pick >= 45 && pick < 90) begin
            idx = $urandom_range(0, mapped_pid.size() - 1);
            pid = mapped_pid[idx];
            addr = mapped_start[idx];
        end
        if (pick < 10) begin
            send_request(prt_pkg::KIND_CREATE, pid, addr, len, prot, flg);
        end else if (pick < 45) begin
            send_request(prt_pkg::KIND_MAP, pid, addr, len, prot, flg);
        end else if (pick < 65) begin
            send_request(prt_pkg::KIND_UNMAP, pid, addr, len, prot, flg);
        end else if (pick < 90) begin
            // probe inside or just past a known start
            send_request(prt_pkg::KIND_FIND, pid,
                         addr + 64'($urandom_range(0, 32'h1_8000)), len, prot, flg);
        end else begin
            // noise: process zero, or an id with arbitrary high bits
            pid = ($urandom_range(0, 1) != 0) ? '0 : $urandom;
            send_request(prt_pkg::KIND_W'($urandom_range(0, 3)), pid, {$urandom, $urandom},
                         {$urandom, $urandom}, prot, flg);
        end
    endtask

    task automatic random_phase(int items);
        repeat (items) random_request();
        drain();
    endtask

    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        table_sb      = new();
        send_idle_pct = 6;
        recv_idle_pct = 55;
        sent_items    = 0;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: auto placement, wrap of the end, bad length, process zero
        send_request(prt_pkg::KIND_CREATE, 32'd1, '0, '0, 8'h00, 8'h00);
        send_request(prt_pkg::KIND_MAP, 32'd1, '0, 64'h1000, 8'hFF, 8'hA5);
        send_request(prt_pkg::KIND_MAP, 32'd1, 64'hFFFF_FFFF_FFFF_F000, 64'h2000,
                     8'h5A, 8'hFF);
        send_request(prt_pkg::KIND_MAP, 32'd1, 64'h1234, '0, 8'h01, 8'h01);
        send_request(prt_pkg::KIND_FIND, 32'd1, 64'h7000_0800, '0, '0, '0);
        send_request(prt_pkg::KIND_FIND, 32'd1, 64'hFFFF_FFFF_FFFF_F800, '0, '0, '0);
        send_request(prt_pkg::KIND_FIND, 32'd1, 64'h7000_1000, '0, '0, '0);
        send_request(prt_pkg::KIND_UNMAP, 32'd1, 64'h7000_0000, '0, '0, '0);
        send_request(prt_pkg::KIND_UNMAP, 32'd99, 64'h7000_0000, '0, '0, '0);
        send_request(prt_pkg::KIND_FIND, 32'd99, 64'h7000_0000, '0, '0, '0);
        send_request(prt_pkg::KIND_MAP, '0, 64'h4000, 64'h10, 8'h3, 8'h3);
        send_request(prt_pkg::KIND_CREATE, '0, '0, '0, '0, '0);
        send_request(prt_pkg::KIND_MAP, 32'hFFFF_FFFF, '0, {64{1'b1}}, 8'h80, 8'h01);
        // fill every region of process 1, the last one overflows
        repeat (8) send_request(prt_pkg::KIND_MAP, 32'd1, '0, 64'h800, 8'h11, 8'h22);
        send_request(prt_pkg::KIND_CREATE, 32'd1, '0, '0, '0, '0);
        send_request(prt_pkg::KIND_FIND, 32'd1, 64'h7000_0100, '0, '0, '0);
        drain();

        random_phase(250);

        send_idle_pct = 55;
        recv_idle_pct = 6;
        write_reg(prt_pkg::CFG_AUTO_BASE, 32'h0);
        write_reg(prt_pkg::CFG_AUTO_STRIDE, 32'h0);
        random_phase(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(prt_pkg::CFG_AUTO_BASE, 32'hFFFF_FFFF);
        write_reg(prt_pkg::CFG_AUTO_STRIDE, 32'hFFFF_FFFF);
        -> hold_start;
        random_phase(250);

        write_reg(prt_pkg::CFG_AUTO_BASE, $urandom);
        write_reg(prt_pkg::CFG_AUTO_STRIDE, $urandom_range(0, 32'h10_0000));
        random_phase(250);

        $display("testbench: %0d requests sent, %0d responses checked over four register",
                 sent_items, table_sb.checked);
        $display("testbench: settings with both-side throttling and a long output stall");
        if (table_sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/prt_pkg.sv
rtl/core/prt_slot_mem.sv
rtl/core/prt_region_mem.sv
rtl/core/process_region_table_core.sv
bench/testbench.sv
